@@ rtl/core/ias_pkg.sv @@
// Shared types and codes for the indexed array store.
// Used by ias_cell, indexed_array_store and the testbench; depends on nothing.
package ias_pkg;

  // Command codes carried by each input item.
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_GET    = 3'd4,
    CMD_SET    = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_WRITE  = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_e;

  // Control word shared by all cells.
  typedef struct packed {
    cell_op_e op;
    logic     rd_en;
  } cell_ctrl_t;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CountW = 9;
  // Cells per first-level branch of the read OR tree.
  localparam int unsigned GroupSize = 16;

endpackage

@@ rtl/core/ias_cell.sv @@
// One storage cell of the shifting chain: holds one entry.
// Depends on ias_pkg for the control word and operation codes.
module ias_cell #(
  parameter int unsigned AW  = 8,
  parameter int unsigned POS = 0
) (
  input  logic                         clk_i,
  input  ias_pkg::cell_ctrl_t          ctrl_i,
  input  logic [AW-1:0]                tgt_i,
  input  logic [AW-1:0]                rd_idx_i,
  input  logic [ias_pkg::DataW-1:0]    wr_value_i,
  input  logic [ias_pkg::DataW-1:0]    left_i,
  input  logic [ias_pkg::DataW-1:0]    right_i,
  output logic [ias_pkg::DataW-1:0]    value_o,
  output logic [ias_pkg::DataW-1:0]    rd_o
);

  localparam logic [AW-1:0] PosC = AW'(POS);

  logic [ias_pkg::DataW-1:0] val_d, val_q;

  // Select the next entry: write, take from the lower or upper neighbor, or hold.
  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      ias_pkg::CELL_WRITE: begin
        if (PosC == tgt_i) val_d = wr_value_i;
      end
      ias_pkg::CELL_INSERT: begin
        if (PosC == tgt_i) val_d = wr_value_i;
        else if (PosC > tgt_i) val_d = left_i;
      end
      ias_pkg::CELL_REMOVE: begin
        if (PosC >= tgt_i) val_d = right_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;
  // Only the addressed cell puts its entry on the read OR tree.
  assign rd_o = (ctrl_i.rd_en && (PosC == rd_idx_i)) ? val_q : '0;

endmodule

@@ rtl/core/indexed_array_store.sv @@
// Top level of the indexed array store: command sequencer, count, cell chain
// and a registered OR tree for reads. Depends on ias_pkg and ias_cell.
//
//  channel | direction | handshake                | fields
//  in      | input     | in_valid_i / in_stall_o  | command_i, index_i, write_value_i
//  out     | output    | out_valid_o / out_stall_i| ok_o, read_value_o, element_count_o
//
// An item is taken in the idle state; in the execute state all cells update at once
// while the addressed entry enters the first OR level, and in the reduce state the
// result is written to the output register once it is free. No new item is taken
// until the block is back in idle, after the cell update and the two-level read tree.
// Reset clears the count and control; entries hold no meaning until written.
// A stalled result stays in the output register; the next item is taken
// meanwhile and waits in the last step until the output register frees.
module indexed_array_store #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 command_i,
  input  logic [7:0]                 index_i,
  input  logic signed [31:0]         write_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic signed [31:0]         read_value_o,
  output logic [8:0]                 element_count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > ias_pkg::IndexW) ? CW : ias_pkg::IndexW;
  localparam int unsigned NG   = (DEPTH + ias_pkg::GroupSize - 1) / ias_pkg::GroupSize;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;

  logic [1:0]                      state_d, state_q;
  logic [CW-1:0]                   count_d, count_q;
  ias_pkg::cmd_e                   cmd_q;
  logic [ias_pkg::IndexW-1:0]      idx_q;
  logic [ias_pkg::DataW-1:0]       wv_q;
  logic                            res_ok_d, res_ok_q;
  logic [ias_pkg::DataW-1:0]       part_q [NG];
  logic [ias_pkg::DataW-1:0]       part_d [NG];
  logic [ias_pkg::DataW-1:0]       rd_sum;
  logic                            out_valid_q, ok_q;
  logic [ias_pkg::DataW-1:0]       rv_q;
  logic [CW-1:0]                   ocount_q;

  ias_pkg::cell_ctrl_t             ctrl;
  logic [AW-1:0]                   tgt, rd_idx;
  logic                            in_range, full, empty;
  logic                            accept, load_out;

  logic [ias_pkg::DataW-1:0]       cell_val [DEPTH];
  logic [ias_pkg::DataW-1:0]       cell_rd  [DEPTH];

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign load_out   = (state_q == S_RED) && (!out_valid_q || !out_stall_i);

  assign in_range = CMPW'(idx_q) < CMPW'(count_q);
  assign full     = (count_q == DepthC);
  assign empty    = (count_q == '0);

  // Decode the held command against the current count.
  always_comb begin
    ctrl.op    = ias_pkg::CELL_HOLD;
    ctrl.rd_en = 1'b0;
    tgt        = AW'(idx_q);
    rd_idx     = AW'(idx_q);
    res_ok_d   = 1'b0;
    count_d    = count_q;
    unique case (cmd_q)
      ias_pkg::CMD_PUSH: begin
        tgt = AW'(count_q);
        if (!full) begin
          ctrl.op  = ias_pkg::CELL_WRITE;
          res_ok_d = 1'b1;
          count_d  = count_q + CW'(1);
        end
      end
      ias_pkg::CMD_POP: begin
        rd_idx = AW'(count_q - CW'(1));
        if (!empty) begin
          ctrl.rd_en = 1'b1;
          res_ok_d   = 1'b1;
          count_d    = count_q - CW'(1);
        end
      end
      ias_pkg::CMD_INSERT: begin
        if (in_range && !full) begin
          ctrl.op  = ias_pkg::CELL_INSERT;
          res_ok_d = 1'b1;
          count_d  = count_q + CW'(1);
        end
      end
      ias_pkg::CMD_REMOVE: begin
        if (in_range) begin
          ctrl.op    = ias_pkg::CELL_REMOVE;
          ctrl.rd_en = 1'b1;
          res_ok_d   = 1'b1;
          count_d    = count_q - CW'(1);
        end
      end
      ias_pkg::CMD_GET: begin
        if (in_range) begin
          ctrl.rd_en = 1'b1;
          res_ok_d   = 1'b1;
        end
      end
      ias_pkg::CMD_SET: begin
        if (in_range) begin
          ctrl.op  = ias_pkg::CELL_WRITE;
          res_ok_d = 1'b1;
        end
      end
      ias_pkg::CMD_CLEAR: begin
        res_ok_d = 1'b1;
        count_d  = '0;
      end
      default: begin
        res_ok_d = 1'b0;
      end
    endcase
    // Cells act only in the execute step.
    if (state_q != S_EXEC) begin
      ctrl.op    = ias_pkg::CELL_HOLD;
      ctrl.rd_en = 1'b0;
    end
  end

  // The chain of cells; each takes from its lower or upper neighbor.
  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    logic [ias_pkg::DataW-1:0] left, right;
    if (p == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[p-1];
    end
    if (p == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[p+1];
    end
    ias_cell #(
      .AW  (AW),
      .POS (p)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .tgt_i      (tgt),
      .rd_idx_i   (rd_idx),
      .wr_value_i (wv_q),
      .left_i     (left),
      .right_i    (right),
      .value_o    (cell_val[p]),
      .rd_o       (cell_rd[p])
    );
  end

  // First OR level: one branch per group of cells.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      part_d[g] = '0;
      for (int k = 0; k < ias_pkg::GroupSize; k++) begin
        if (g * ias_pkg::GroupSize + k < DEPTH) begin
          part_d[g] = part_d[g] | cell_rd[g * ias_pkg::GroupSize + k];
        end
      end
    end
  end

  // Second OR level over the registered branches.
  always_comb begin
    rd_sum = '0;
    for (int g = 0; g < NG; g++) begin
      rd_sum = rd_sum | part_q[g];
    end
  end

  // Sequencer state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: state_d = S_RED;
      S_RED:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) count_q <= count_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers: held item, first tree level and output.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= ias_pkg::cmd_e'(command_i);
      idx_q <= index_i;
      wv_q  <= write_value_i;
    end
    if (state_q == S_EXEC) begin
      res_ok_q <= res_ok_d;
      for (int g = 0; g < NG; g++) part_q[g] <= part_d[g];
    end
    if (load_out) begin
      ok_q     <= res_ok_q;
      rv_q     <= rd_sum;
      ocount_q <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign read_value_o    = rv_q;
  assign element_count_o = ias_pkg::CountW'(ocount_q);

endmodule

@@ rtl/core/ias_checker.sv @@
// Port-level checks for indexed_array_store, attached by the bind below.
// Depends on indexed_array_store's port list only.
module ias_checker #(
  parameter int unsigned DEPTH = 256
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               ok_o,
  input logic signed [31:0] read_value_o,
  input logic [8:0]         element_count_o
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_value_o)
      && $stable(ok_o) && $stable(element_count_o)))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item taken while previous one still executing");

  // A rejected command reports a zero read value.
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (read_value_o == '0))
    else $error("rejected command returned data");

  // The reported count never exceeds the store depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(element_count_o) <= DEPTH))
    else $error("count above depth");

  // No result appears unless the block was busy with an item beforehand.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 1) && $past(in_stall_o, 2))
    else $error("result without a preceding item");

endmodule

bind indexed_array_store ias_checker #(.DEPTH(DEPTH)) u_ias_checker (.*);

@@ test/indexed_array_store_test.sv @@
// Self-checking testbench for indexed_array_store: a queue-fed driver, a result
// monitor and an in-bench list model that predicts every result.
// Depends on ias_pkg and the indexed_array_store RTL only.
module indexed_array_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned TotalItems = 750;
  localparam int unsigned IdlePercent = 26;
  // Window of items and results with no idling on either side.
  localparam int unsigned QuietFrom = 400;
  localparam int unsigned QuietTo = 520;
  localparam int unsigned SettleCycles = 12;
  // Code 7 has no command behind it; the block must answer with a rejection.
  localparam logic [2:0] CmdUnused = 3'd7;

  typedef struct {
    logic [2:0]         command;
    logic [7:0]         index;
    logic signed [31:0] write_value;
    bit                 wait_drained;
  } store_cmd_t;

  typedef struct {
    logic               ok;
    logic signed [31:0] read_value;
    logic [8:0]         count;
  } store_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         command_i = ias_pkg::CMD_PUSH;
  logic [7:0]         index_i = 8'd0;
  logic signed [31:0] write_value_i = 32'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               ok_o;
  logic signed [31:0] read_value_o;
  logic [8:0]         element_count_o;

  store_cmd_t    pending_cmds[$];
  store_result_t expected_results[$];
  int unsigned   items_taken = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatch_count = 0;

  // List image kept by the predictor.
  logic signed [31:0] store_image [0:StoreDepth-1];
  logic [8:0]         held_count = 9'd0;

  // Count the stimulus planner expects, used to aim indexes and to fill the store.
  int unsigned plan_count = 0;
  bit          hold_next = 1'b0;

  indexed_array_store #(
    .DEPTH(StoreDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .index_i        (index_i),
    .write_value_i  (write_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ok_o           (ok_o),
    .read_value_o   (read_value_o),
    .element_count_o(element_count_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
  endtask

  // Apply one command to the list image and give the result it must produce.
  task automatic apply_command(input store_cmd_t c, output store_result_t r);
    bit in_range;
    int i;
    r.ok = 1'b0;
    r.read_value = 32'sd0;
    in_range = c.index < held_count;
    case (c.command)
      ias_pkg::CMD_PUSH: begin
        if (held_count < StoreDepth) begin
          store_image[held_count[7:0]] = c.write_value;
          held_count++;
          r.ok = 1'b1;
        end
      end
      ias_pkg::CMD_POP: begin
        if (held_count != 0) begin
          held_count--;
          r.read_value = store_image[held_count[7:0]];
          r.ok = 1'b1;
        end
      end
      ias_pkg::CMD_INSERT: begin
        if (in_range && held_count < StoreDepth) begin
          for (i = held_count; i > c.index; i--) begin
            store_image[8'(i)] = store_image[8'(i - 1)];
          end
          store_image[c.index] = c.write_value;
          held_count++;
          r.ok = 1'b1;
        end
      end
      ias_pkg::CMD_REMOVE: begin
        if (in_range) begin
          r.read_value = store_image[c.index];
          for (i = c.index; i + 1 < held_count; i++) begin
            store_image[8'(i)] = store_image[8'(i + 1)];
          end
          held_count--;
          r.ok = 1'b1;
        end
      end
      ias_pkg::CMD_GET: begin
        if (in_range) begin
          r.read_value = store_image[c.index];
          r.ok = 1'b1;
        end
      end
      ias_pkg::CMD_SET: begin
        if (in_range) begin
          store_image[c.index] = c.write_value;
          r.ok = 1'b1;
        end
      end
      ias_pkg::CMD_CLEAR: begin
        held_count = 9'd0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = held_count;
  endtask

  // Append one command to the stimulus and track the count it leads to.
  task automatic plan_cmd(input logic [2:0] command, input logic [7:0] index,
                          input logic signed [31:0] value);
    store_cmd_t c;
    c.command = command;
    c.index = index;
    c.write_value = value;
    c.wait_drained = hold_next;
    hold_next = 1'b0;
    pending_cmds.push_back(c);
    case (command)
      ias_pkg::CMD_PUSH:   if (plan_count < StoreDepth) plan_count++;
      ias_pkg::CMD_POP:    if (plan_count != 0) plan_count--;
      ias_pkg::CMD_INSERT: if (index < plan_count && plan_count < StoreDepth) plan_count++;
      ias_pkg::CMD_REMOVE: if (index < plan_count) plan_count--;
      ias_pkg::CMD_CLEAR:  plan_count = 0;
      default: ;
    endcase
  endtask

  // Mostly a valid index, often at either end of the list.
  function automatic logic [7:0] pick_index();
    int unsigned top;
    top = plan_count - 1;
    if (plan_count != 0 && $urandom_range(99) < 85) begin
      case ($urandom_range(3))
        0: return 8'd0;
        1: return top[7:0];
        default: return 8'($urandom_range(top));
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Random word, with the sign and zero extremes mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // One random command; push_bias adds pushes to keep the list growing.
  task automatic plan_random_op(input int unsigned push_bias);
    int unsigned roll;
    logic [2:0] op;
    roll = $urandom_range(99);
    if (roll < push_bias) begin
      op = ias_pkg::CMD_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < 14) op = ias_pkg::CMD_POP;
      else if (roll < 32) op = ias_pkg::CMD_INSERT;
      else if (roll < 50) op = ias_pkg::CMD_REMOVE;
      else if (roll < 68) op = ias_pkg::CMD_GET;
      else if (roll < 86) op = ias_pkg::CMD_SET;
      else if (roll < 88) op = ias_pkg::CMD_CLEAR;
      else if (roll < 89) op = CmdUnused;
      else op = ias_pkg::CMD_PUSH;
    end
    plan_cmd(op, pick_index(), pick_value());
  endtask

  // Driver: present queued items, predict each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    store_result_t predicted;
    bit            took;
    bit            drained;
    bit            may_idle;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i <= ias_pkg::CMD_PUSH;
      index_i <= 8'd0;
      write_value_i <= 32'sd0;
      items_taken <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        apply_command(pending_cmds[0], predicted);
        expected_results.push_back(predicted);
        void'(pending_cmds.pop_front());
        items_taken <= items_taken + 1;
      end
      drained = (items_taken + took) == results_seen;
      may_idle = !(items_taken >= QuietFrom && items_taken < QuietTo);
      if (in_valid_i && !took) begin
        // A stalled item is held as it is.
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].wait_drained && !drained) &&
                   !(may_idle && $urandom_range(99) < IdlePercent)) begin
        in_valid_i <= 1'b1;
        command_i <= pending_cmds[0].command;
        index_i <= pending_cmds[0].index;
        write_value_i <= pending_cmds[0].write_value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    store_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", read_value_o, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (ok_o !== want.ok) report_mismatch("ok", 32'(ok_o), 32'(want.ok));
          if (read_value_o !== want.read_value) begin
            report_mismatch("read_value", read_value_o, want.read_value);
          end
          if (element_count_o !== want.count) begin
            report_mismatch("element_count", 32'(element_count_o), 32'(want.count));
          end
        end
      end
      if (results_seen >= QuietFrom && results_seen < QuietTo) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IdlePercent);
      end
    end
  end

  // Stimulus plan, reset, and the end of the run.
  initial begin
    // Rejections on an empty list.
    plan_cmd(ias_pkg::CMD_POP, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_GET, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_REMOVE, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_SET, 8'd0, 32'sd5);
    plan_cmd(ias_pkg::CMD_INSERT, 8'd0, 32'sd9);
    // Value extremes, then inserts at the front and before the last entry.
    plan_cmd(ias_pkg::CMD_PUSH, 8'd255, 32'sh7fffffff);
    plan_cmd(ias_pkg::CMD_PUSH, 8'd0, 32'sh80000000);
    plan_cmd(ias_pkg::CMD_PUSH, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_PUSH, 8'd0, -32'sd1);
    plan_cmd(ias_pkg::CMD_INSERT, 8'd0, 32'sh55555555);
    plan_cmd(ias_pkg::CMD_INSERT, 8'd4, 32'shaaaaaaaa);
    // Insert at the count cannot append.
    plan_cmd(ias_pkg::CMD_INSERT, 8'd6, 32'sd3);
    plan_cmd(ias_pkg::CMD_GET, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_GET, 8'd5, 32'sd0);
    plan_cmd(ias_pkg::CMD_GET, 8'd255, 32'sd0);
    plan_cmd(ias_pkg::CMD_SET, 8'd2, 32'sd12345);
    plan_cmd(ias_pkg::CMD_REMOVE, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_REMOVE, 8'd4, 32'sd0);
    plan_cmd(ias_pkg::CMD_REMOVE, 8'd4, 32'sd0);
    plan_cmd(ias_pkg::CMD_POP, 8'd0, 32'sd0);
    plan_cmd(CmdUnused, 8'd255, -32'sd1);
    plan_cmd(ias_pkg::CMD_GET, 8'd1, 32'sd0);
    plan_cmd(ias_pkg::CMD_CLEAR, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_POP, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_GET, 8'd0, 32'sd0);

    // Fill the store to the top with random content, after a full drain.
    hold_next = 1'b1;
    while (plan_count < StoreDepth) begin
      case ($urandom_range(9))
        0:       plan_cmd(ias_pkg::CMD_INSERT, pick_index(), pick_value());
        1:       plan_cmd(ias_pkg::CMD_GET, pick_index(), 32'sd0);
        2:       plan_cmd(ias_pkg::CMD_SET, pick_index(), pick_value());
        default: plan_cmd(ias_pkg::CMD_PUSH, 8'd0, pick_value());
      endcase
    end
    // Full store: growth is refused, the top slot is reachable.
    plan_cmd(ias_pkg::CMD_PUSH, 8'd0, 32'sd1);
    plan_cmd(ias_pkg::CMD_INSERT, 8'd0, 32'sd2);
    plan_cmd(ias_pkg::CMD_INSERT, 8'd255, 32'sd3);
    plan_cmd(ias_pkg::CMD_GET, 8'd255, 32'sd0);
    plan_cmd(ias_pkg::CMD_SET, 8'd255, 32'sh80000000);
    plan_cmd(ias_pkg::CMD_REMOVE, 8'd255, 32'sd0);
    plan_cmd(ias_pkg::CMD_REMOVE, 8'd0, 32'sd0);
    plan_cmd(ias_pkg::CMD_INSERT, 8'd254, 32'sh7fffffff);
    plan_cmd(ias_pkg::CMD_PUSH, 8'd0, -32'sd1);
    plan_cmd(ias_pkg::CMD_GET, 8'd128, 32'sd0);
    repeat (80) plan_random_op(45);

    // Start over from an empty list and mix everything.
    hold_next = 1'b1;
    plan_cmd(ias_pkg::CMD_CLEAR, 8'd0, 32'sd0);
    while (pending_cmds.size() < TotalItems) plan_random_op(12);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_cmds.size() != 0 || items_taken != results_seen) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("missing results", 32'd0, 32'(expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("indexed_array_store_test: clean");
    end else begin
      $display("indexed_array_store_test: errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #1_200_000;
    $display("indexed_array_store_test: errors");
    $finish;
  end

endmodule
